>>> rtl/core/lzi_pkg.sv
// ----------------------------------------------------------------------------
// lzi_pkg: shared types and constants for the Zaremba index block
// Widths, divider request/response structs.
// ----------------------------------------------------------------------------
package lzi_pkg;

  localparam int MOD_WIDTH = 16;
  localparam int GEN_WIDTH = 16;
  localparam int RHO_WIDTH = 16;
  localparam int NUM_GEN   = 4;
  localparam int DIV_WIDTH = 2 * MOD_WIDTH;
  localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(101);

  // divider start request
  typedef struct packed {
    logic                 start;
    logic [DIV_WIDTH-1:0] dividend;
    logic [MOD_WIDTH-1:0] divisor;
  } div_req_t;

  // divider result, done pulses for one cycle
  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [DIV_WIDTH-1:0] quot;
    logic [MOD_WIDTH-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/core/lzi_div.sv
// ----------------------------------------------------------------------------
// lzi_div: shared restoring divider
// One quotient bit per cycle; quotient and remainder held until next start.
// ----------------------------------------------------------------------------
module lzi_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lzi_pkg::div_req_t req_i,
  output lzi_pkg::div_rsp_t rsp_o
);
  import lzi_pkg::*;

  localparam int CNT_W = $clog2(DIV_WIDTH);

  logic [DIV_WIDTH-1:0] quot_q;
  logic [MOD_WIDTH-1:0] rem_q;
  logic [MOD_WIDTH-1:0] divisor_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [MOD_WIDTH:0]   shifted;
  logic [MOD_WIDTH:0]   diff;
  logic                 take;

  assign shifted = {rem_q, quot_q[DIV_WIDTH-1]};
  assign diff    = shifted - {1'b0, divisor_q};
  assign take    = shifted >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q    <= 1'b1;
        cnt_q     <= '0;
        quot_q    <= req_i.dividend;
        rem_q     <= '0;
        divisor_q <= req_i.divisor;
      end else if (busy_q) begin
        rem_q  <= take ? diff[MOD_WIDTH-1:0] : shifted[MOD_WIDTH-1:0];
        quot_q <= {quot_q[DIV_WIDTH-2:0], take};
        cnt_q  <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < divisor_q) else $error("remainder not reduced");

endmodule

>>> rtl/core/lattice_zaremba_index_5d.sv
// ----------------------------------------------------------------------------
// lattice_zaremba_index_5d: Zaremba index of a 5-D rank-1 lattice
// Early trit check, singleton seed, then branch-and-bound over h2..h5.
// ----------------------------------------------------------------------------
// Operation: the four generators are reduced mod N on the shared divider,
//   then the early check steps through the trit combinations, then a
//   data-dependent search; each loop entry takes two shared divider passes
//   (limit and start residue), one when the loop starts at zero.
// Throughput: one item at a time; in_stall_o is high until the result is
//   registered. The shared multiplier/divider pair sets the pace.
// Reset: modulus returns to 101, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module lattice_zaremba_index_5d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lzi_pkg::MOD_WIDTH-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lzi_pkg::GEN_WIDTH-1:0] gen_two_i,
  input  logic [lzi_pkg::GEN_WIDTH-1:0] gen_three_i,
  input  logic [lzi_pkg::GEN_WIDTH-1:0] gen_four_i,
  input  logic [lzi_pkg::GEN_WIDTH-1:0] gen_five_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lzi_pkg::RHO_WIDTH-1:0] rho_o
);
  import lzi_pkg::*;

  localparam int W = MOD_WIDTH;

  // trit digit codes: coefficient -1, 0, +1
  localparam logic [1:0] TRIT_NEG  = 2'd0;
  localparam logic [1:0] TRIT_ZERO = 2'd1;
  localparam logic [1:0] TRIT_POS  = 2'd2;

  // loop levels below h2: h3, h4, h5
  localparam logic [1:0] LVL_H3 = 2'd0;
  localparam logic [1:0] LVL_H5 = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GM_ISSUE, ST_GM_WAIT, ST_EARLY, ST_SEED,
    ST_H2_TEST, ST_H2_DIV, ST_START, ST_S_MUL, ST_S_WAIT,
    ST_L_TEST, ST_L_MUL, ST_L_DIV, ST_L_SCORE, ST_L_CMP, ST_L_ADV, ST_FIN
  } state_e;

  state_e state_q;

  logic [W-1:0]         n_q;
  logic [GEN_WIDTH-1:0] g_q   [NUM_GEN];
  logic [W-1:0]         gm_q  [NUM_GEN];   // generators reduced mod N
  logic [1:0]           gidx_q;
  logic [1:0]           trit_q[NUM_GEN];
  logic [W-1:0]         best_q;
  logic [W-1:0]         h2_q;
  logic [W-1:0]         r2_q;              // h2*g2 mod N
  logic [1:0]           lvl_q;
  logic signed [W:0]    h_q   [3];
  logic [W-1:0]         lim_q [3];
  logic [W-1:0]         res_q [3];         // running sum mod N down to level
  logic [W-1:0]         pf_q  [3];         // product of the levels above
  logic [W-1:0]         p5_q;
  logic [2*W-1:0]       mul_q;
  logic                 out_valid_q;
  logic [RHO_WIDTH-1:0] rho_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  lzi_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // (a + b) mod n for a, b < n
  function automatic logic [W-1:0] mod_add(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] n);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[W-1:0];
  endfunction

  // (-a) mod n
  function automatic logic [W-1:0] mod_neg(logic [W-1:0] a, logic [W-1:0] n);
    return (a == '0) ? '0 : n - a;
  endfunction

  // magnitude of the symmetric residue, floored at one
  function automatic logic [W-1:0] sym_mag1(logic [W-1:0] r, logic [W-1:0] n);
    logic [W-1:0] m;
    m = (r < n - r) ? r : n - r;
    return (m == '0) ? W'(1) : m;
  endfunction

  // ---- current level views ----
  logic signed [W:0] cur_h;
  logic [W-1:0]      cur_lim, cur_res, cur_pf, gm_lvl, h_abs1, f2;
  logic [1:0]        lvl_nx;
  logic              h_over, all_zero, p_ge_best;

  assign lvl_nx  = lvl_q + 2'd1;
  assign cur_h   = h_q[lvl_q];
  assign cur_lim = lim_q[lvl_q];
  assign cur_res = res_q[lvl_q];
  assign cur_pf  = pf_q[lvl_q];
  assign gm_lvl  = gm_q[lvl_nx];
  assign f2      = (h2_q == '0) ? W'(1) : h2_q;

  always_comb begin
    logic [W:0] a;
    a      = cur_h[W] ? -cur_h : cur_h;
    h_abs1 = (a[W-1:0] == '0) ? W'(1) : a[W-1:0];
  end

  assign h_over    = cur_h > $signed({1'b0, cur_lim});
  assign p_ge_best = mul_q >= {{W{1'b0}}, best_q};
  // all outer indices zero: this level starts at 0, or at 1 for h5
  assign all_zero  = (h2_q == '0) && (lvl_q == LVL_H3 || h_q[0] == '0) &&
                     (lvl_q != LVL_H5 || h_q[1] == '0);

  // ---- shared multiplier, one registered product per cycle ----
  logic [W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = cur_pf;
    mul_b = h_abs1;
    unique case (state_q)
      ST_START:   begin mul_a = cur_lim; mul_b = gm_lvl; end
      ST_L_SCORE: begin mul_a = p5_q;    mul_b = sym_mag1(res_q[2], n_q); end
      default:    begin mul_a = cur_pf;  mul_b = h_abs1; end
    endcase
  end

  // ---- early check: one trit combination per cycle ----
  logic [W+1:0] e_sum, e_red;
  logic [W-1:0] e_res;
  logic         e_zero_code, e_last, e_hit;
  always_comb begin
    logic [W+1:0] nn, nn2, nn3;
    e_sum       = '0;
    e_zero_code = 1'b1;
    e_last      = 1'b1;
    for (int i = 0; i < NUM_GEN; i++) begin
      unique case (trit_q[i])
        TRIT_POS:  e_sum = e_sum + (W+2)'(gm_q[i]);
        TRIT_NEG:  e_sum = e_sum + (W+2)'(mod_neg(gm_q[i], n_q));
        default:   e_sum = e_sum;
      endcase
      if (trit_q[i] != TRIT_ZERO) e_zero_code = 1'b0;
      if (trit_q[i] != TRIT_POS)  e_last = 1'b0;
    end
    nn  = (W+2)'(n_q);
    nn2 = nn << 1;
    nn3 = nn2 + nn;
    priority if (e_sum >= nn3) e_red = e_sum - nn3;
    else if (e_sum >= nn2)     e_red = e_sum - nn2;
    else if (e_sum >= nn)      e_red = e_sum - nn;
    else                       e_red = e_sum;
    e_res = e_red[W-1:0];
    e_hit = !e_zero_code && (e_res <= W'(1) || n_q - e_res <= W'(1));
  end

  // ---- singleton seed ----
  logic [W-1:0] seed;
  always_comb begin
    logic [W-1:0] c;
    seed = n_q;
    for (int i = 0; i < NUM_GEN; i++) begin
      c = sym_mag1(gm_q[i], n_q);
      if (c < seed) seed = c;
    end
  end

  // ---- divider requests ----
  logic h2_go, l_go;
  assign h2_go = (h2_q < best_q) && (f2 < best_q);
  assign l_go  = !p_ge_best && (lvl_q != LVL_H5);

  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_GM_ISSUE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_WIDTH'(g_q[gidx_q]);
        div_req.divisor  = n_q;
      end
      ST_H2_TEST: begin
        div_req.start    = h2_go;
        div_req.dividend = DIV_WIDTH'(best_q - W'(1));
        div_req.divisor  = f2;
      end
      ST_S_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_q;
        div_req.divisor  = n_q;
      end
      ST_L_MUL: begin
        div_req.start    = l_go;
        div_req.dividend = DIV_WIDTH'(best_q - W'(1));
        div_req.divisor  = mul_q[W-1:0];
      end
      default: div_req = '0;
    endcase
  end

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= MOD_RESET;
      out_valid_q <= 1'b0;
      gidx_q      <= '0;
      lvl_q       <= '0;
      best_q      <= '1;
    end else begin
      mul_q <= mul_a * mul_b;
      if (cfg_we_i) n_q <= cfg_data_i;
      // a new result in ST_FIN takes the slot freed by this transfer
      if (out_xfer && state_q != ST_FIN) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            g_q[0] <= gen_two_i;
            g_q[1] <= gen_three_i;
            g_q[2] <= gen_four_i;
            g_q[3] <= gen_five_i;
            gidx_q <= '0;
            if (n_q < W'(2)) begin
              // degenerate modulus: every residue is zero
              best_q  <= W'(1);
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_GM_ISSUE;
            end
          end
        end
        ST_GM_ISSUE: state_q <= ST_GM_WAIT;
        ST_GM_WAIT: begin
          if (div_rsp.done) begin
            gm_q[gidx_q] <= div_rsp.rem;
            gidx_q       <= gidx_q + 2'd1;
            if (gidx_q == 2'(NUM_GEN - 1)) begin
              for (int i = 0; i < NUM_GEN; i++) trit_q[i] <= TRIT_NEG;
              state_q <= ST_EARLY;
            end else begin
              state_q <= ST_GM_ISSUE;
            end
          end
        end
        ST_EARLY: begin
          priority if (e_hit) begin
            best_q  <= W'(1);
            state_q <= ST_FIN;
          end else if (e_last) begin
            state_q <= ST_SEED;
          end else begin
            // base-3 increment, lowest digit first
            if (trit_q[0] != TRIT_POS) trit_q[0] <= trit_q[0] + 2'd1;
            else begin
              trit_q[0] <= TRIT_NEG;
              if (trit_q[1] != TRIT_POS) trit_q[1] <= trit_q[1] + 2'd1;
              else begin
                trit_q[1] <= TRIT_NEG;
                if (trit_q[2] != TRIT_POS) trit_q[2] <= trit_q[2] + 2'd1;
                else begin
                  trit_q[2] <= TRIT_NEG;
                  trit_q[3] <= trit_q[3] + 2'd1;
                end
              end
            end
          end
        end
        ST_SEED: begin
          best_q  <= seed;
          h2_q    <= '0;
          r2_q    <= '0;
          state_q <= ST_H2_TEST;
        end
        ST_H2_TEST: begin
          if (h2_go) state_q <= ST_H2_DIV;
          else       state_q <= ST_FIN;
        end
        ST_H2_DIV: begin
          if (div_rsp.done) begin
            lim_q[0] <= div_rsp.quot[W-1:0];
            pf_q[0]  <= f2;
            res_q[0] <= r2_q;
            lvl_q    <= LVL_H3;
            state_q  <= ST_START;
          end
        end
        ST_START: begin
          if (all_zero) begin
            if (lvl_q == LVL_H5) begin
              h_q[lvl_q]   <= (W+1)'(1);
              res_q[lvl_q] <= mod_add(cur_res, gm_lvl, n_q);
            end else begin
              h_q[lvl_q] <= '0;
            end
            state_q <= ST_L_TEST;
          end else begin
            // start at -lim; residue offset comes from lim*g mod N
            h_q[lvl_q] <= -$signed({1'b0, cur_lim});
            state_q    <= ST_S_MUL;
          end
        end
        ST_S_MUL: state_q <= ST_S_WAIT;
        ST_S_WAIT: begin
          if (div_rsp.done) begin
            res_q[lvl_q] <= mod_add(cur_res, mod_neg(div_rsp.rem, n_q), n_q);
            state_q      <= ST_L_TEST;
          end
        end
        ST_L_TEST: begin
          if (h_over) begin
            if (lvl_q == LVL_H3) begin
              h2_q    <= h2_q + W'(1);
              r2_q    <= mod_add(r2_q, gm_q[0], n_q);
              state_q <= ST_H2_TEST;
            end else begin
              lvl_q   <= lvl_q - 2'd1;
              state_q <= ST_L_ADV;
            end
          end else begin
            state_q <= ST_L_MUL;
          end
        end
        ST_L_MUL: begin
          priority if (p_ge_best) begin
            state_q <= ST_L_ADV;
          end else if (lvl_q != LVL_H5) begin
            pf_q[lvl_nx]  <= mul_q[W-1:0];
            res_q[lvl_nx] <= cur_res;
            state_q       <= ST_L_DIV;
          end else begin
            p5_q    <= mul_q[W-1:0];
            state_q <= ST_L_SCORE;
          end
        end
        ST_L_DIV: begin
          if (div_rsp.done) begin
            lim_q[lvl_nx] <= div_rsp.quot[W-1:0];
            lvl_q         <= lvl_nx;
            state_q       <= ST_START;
          end
        end
        ST_L_SCORE: state_q <= ST_L_CMP;
        ST_L_CMP: begin
          if (mul_q < {{W{1'b0}}, best_q}) best_q <= mul_q[W-1:0];
          state_q <= ST_L_ADV;
        end
        ST_L_ADV: begin
          h_q[lvl_q]   <= cur_h + (W+1)'(1);
          res_q[lvl_q] <= mod_add(cur_res, gm_lvl, n_q);
          state_q      <= ST_L_TEST;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            rho_q       <= RHO_WIDTH'(best_q);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign rho_o       = rho_q;

  // bound only tightens once the search is seeded
  a_best_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_SEED) |=> best_q <= $past(best_q))
    else $error("bound increased during search");
  a_rho_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> rho_q != '0) else $error("zero index delivered");
  a_res_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_L_TEST |-> cur_res < n_q) else $error("residue not reduced");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_H5) else $error("loop level out of range");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for lattice_zaremba_index_5d
// Streams generator vectors under several modulus settings, predicts rho
// with an in-bench branch-and-bound search and checks every output transfer.
// ----------------------------------------------------------------------------
module tb;
  import lzi_pkg::*;

  typedef struct {
    logic [GEN_WIDTH-1:0] g2, g3, g4, g5;
  } gen_vec_t;

  localparam int unsigned STALL_LIMIT = 10000000; // idle cycles before giving up
  localparam int unsigned DRAIN_WAIT  = 400;      // settle cycles after last result

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [MOD_WIDTH-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [GEN_WIDTH-1:0] gen_two_i = '0, gen_three_i = '0, gen_four_i = '0, gen_five_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [RHO_WIDTH-1:0] rho_o;

  lattice_zaremba_index_5d i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .gen_two_i, .gen_three_i, .gen_four_i, .gen_five_i,
    .out_valid_o, .out_stall_i, .rho_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gen_vec_t             vec_pending[$];  // vectors waiting to be driven
  logic [RHO_WIDTH-1:0] rho_expected[$]; // predicted rho per accepted vector
  logic [MOD_WIDTH-1:0] cur_modulus = MOD_RESET;  // bench copy of the register
  int unsigned n_err = 0, n_in = 0, n_out = 0, idle_cycles = 0, n_settings = 1;
  bit in_taken = 1'b0;

  // -------------------------------------------------------------------------
  // Rho predictor
  // -------------------------------------------------------------------------
  // symmetric residue of -s mod n, in (-n/2 .. n/2]
  function automatic longint sym_residue(longint s, longint n);
    longint r;
    r = (-s) % n;
    if (r < 0) r += n;
    if (r > n / 2) r -= n;
    return r;
  endfunction

  function automatic longint abs_val(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint floor1(longint v);
    return (v > 1) ? v : 1;
  endfunction

  function automatic logic [RHO_WIDTH-1:0] predict_rho(longint n, gen_vec_t v);
    longint g[4];
    longint coef, s, bound, f2, p23, p234, p, lim3, lim4, lim5, st3, st4, st5, score;
    int c;
    bit nz;
    g[0] = v.g2; g[1] = v.g3; g[2] = v.g4; g[3] = v.g5;
    if (n < 2) return 1;
    // every {-1,0,1} combination: a residue of magnitude <= 1 settles rho = 1
    for (int code = 0; code < 81; code++) begin
      c = code; s = 0; nz = 1'b0;
      for (int i = 0; i < 4; i++) begin
        coef = longint'(c % 3) - 1;
        c = c / 3;
        if (coef != 0) nz = 1'b1;
        s += coef * g[i];
      end
      if (nz && abs_val(sym_residue(s, n)) <= 1) return 1;
    end
    bound = n;
    for (int i = 0; i < 4; i++) begin
      if (floor1(abs_val(sym_residue(g[i], n))) < bound)
        bound = floor1(abs_val(sym_residue(g[i], n)));
      if (floor1(abs_val(sym_residue(-g[i], n))) < bound)
        bound = floor1(abs_val(sym_residue(-g[i], n)));
    end
    // branch and bound; loop limits re-read the live bound
    for (longint h2 = 0; h2 < bound; h2++) begin
      f2 = floor1(h2);
      if (f2 >= bound) break;
      lim3 = (bound - 1) / f2;
      st3 = (h2 == 0) ? 0 : -lim3;
      for (longint h3 = st3; h3 <= lim3; h3++) begin
        p23 = f2 * floor1(abs_val(h3));
        if (p23 >= bound) continue;
        lim4 = (bound - 1) / p23;
        st4 = (h2 == 0 && h3 == 0) ? 0 : -lim4;
        for (longint h4 = st4; h4 <= lim4; h4++) begin
          p234 = p23 * floor1(abs_val(h4));
          if (p234 >= bound) continue;
          lim5 = (bound - 1) / p234;
          st5 = (h2 == 0 && h3 == 0 && h4 == 0) ? 1 : -lim5;
          for (longint h5 = st5; h5 <= lim5; h5++) begin
            p = p234 * floor1(abs_val(h5));
            if (p >= bound) continue;
            s = h2 * g[0] + h3 * g[1] + h4 * g[2] + h5 * g[3];
            score = p * floor1(abs_val(sym_residue(s, n)));
            if (score < bound) bound = score;
          end
        end
      end
    end
    return bound[RHO_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch @%0t: %s", $realtime, what);
    n_err++;
  endtask

  // -------------------------------------------------------------------------
  // Driver: new payload at the falling edge, transfer seen at the rising edge
  // -------------------------------------------------------------------------
  // no idling while transfers 40..79 happen on the input side
  function automatic bit quiet_window();
    return (n_in >= 40 && n_in < 80);
  endfunction

  always @(posedge clk_i) begin
    in_taken <= 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rho_expected.push_back(predict_rho(longint'(cur_modulus),
        gen_vec_t'{gen_two_i, gen_three_i, gen_four_i, gen_five_i}));
      n_in++;
      in_taken <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    gen_vec_t v;
    // a held payload stays put until it is transferred
    if (!in_valid_i || in_taken) begin
      if (vec_pending.size() != 0 && (quiet_window() || $urandom_range(99) >= 8)) begin
        v = vec_pending.pop_front();
        in_valid_i  <= 1'b1;
        gen_two_i   <= v.g2;
        gen_three_i <= v.g3;
        gen_four_i  <= v.g4;
        gen_five_i  <= v.g5;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= (!quiet_window() && $urandom_range(99) < 8);
  end

  // -------------------------------------------------------------------------
  // Monitor and watchdog
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [RHO_WIDTH-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (rho_expected.size() == 0) begin
        report_mismatch($sformatf("rho %0d with no vector outstanding", rho_o));
      end else begin
        want = rho_expected.pop_front();
        if (rho_o !== want)
          report_mismatch($sformatf("rho got %0d want %0d", rho_o, want));
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  function automatic gen_vec_t rand_vec();
    return gen_vec_t'{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  task automatic queue_vec(int unsigned a, int unsigned b, int unsigned c, int unsigned d);
    vec_pending.push_back(gen_vec_t'{16'(a), 16'(b), 16'(c), 16'(d)});
  endtask

  // sender holds off until the block has drained, then the register moves
  task automatic drain_and_set(logic [MOD_WIDTH-1:0] m);
    while (vec_pending.size() != 0 || in_valid_i || rho_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_modulus = m;
    n_settings++;
  endtask

  initial begin
    gen_vec_t v;
    logic [MOD_WIDTH-1:0] m;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset modulus: field extremes, trit-hit, ordinary searches
    queue_vec(0, 0, 0, 0);
    queue_vec(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_vec(1, 2, 3, 4);
    queue_vec(10, 20, 30, 40);
    queue_vec(40, 85, 23, 67);
    queue_vec(16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA);
    // degenerate moduli, including the ones the range leaves out
    drain_and_set(2);   queue_vec(1, 0, 1, 0);
    drain_and_set(0);   queue_vec(1234, 5, 16'hFFFF, 77);
    drain_and_set(1);   queue_vec(9, 9, 9, 9);
    // widest modulus; one small singleton keeps the search short
    drain_and_set(16'hFFFF);
    queue_vec(2, 16'hFFFF, 0, 16'h8000);
    queue_vec(16'hFFFC, 1000, 3000, 20000);
    queue_vec(5, 12345, 23456, 34567);
    drain_and_set(3);   queue_vec(1, 2, 2, 1);
    drain_and_set(97);
    queue_vec(22, 35, 71, 90);
    queue_vec(97, 194, 291, 388);   // multiples of N
    queue_vec(10, 47, 13, 88);

    // random: mostly moderate moduli, one wide setting with a short singleton
    for (int ph = 0; ph < 8; ph++) begin
      m = (ph == 3) ? 16'hFFFF : 16'($urandom_range(5, 300));
      drain_and_set(m);
      for (int k = 0; k < 16; k++) begin
        v = rand_vec();
        if (m > 1000) v.g2 = 16'($urandom_range(2, 24));
        vec_pending.push_back(v);
      end
    end

    while (vec_pending.size() != 0 || in_valid_i || rho_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (rho_expected.size() != 0) report_mismatch("results still outstanding at end");
    $display("covered %0d vectors, %0d results, %0d modulus settings incl. 0, 1 and 65535",
             n_in, n_out, n_settings);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lzi_pkg.sv
rtl/core/lzi_div.sv
rtl/core/lattice_zaremba_index_5d.sv
dv/tb.sv
